@@ hw/rtl/eycc_to_rgb_rounding_assert.svh @@
// Assertion macros for the extended YCC to RGB converter.
// Included by files that check their own logic; depends on nothing else.
`ifndef EYCC_TO_RGB_ROUNDING_ASSERT_SVH
`define EYCC_TO_RGB_ROUNDING_ASSERT_SVH
`ifndef SYNTHESIS
`define EYCC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("eycc assertion failed");
`define EYCC_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("eycc forbidden condition seen");
`else
`define EYCC_ASSERT(label, clk, rst, prop)
`define EYCC_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

@@ hw/rtl/eycc_pkg.sv @@
// Shared widths, matrix coefficients, register indexes and word types
// for the extended YCC to RGB converter. Depends on nothing.
package eycc_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int IN_W        = SAMPLE_BITS + 1;
   localparam int REG_W       = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CHR_W       = ((IN_W > REG_W + 1) ? IN_W : REG_W + 1) + 1;
   localparam int COEF_FRAC   = 24;
   localparam int COEF_W      = 26;
   localparam int PROD_W      = COEF_W + CHR_W;
   localparam int SUM_W       = PROD_W + 2;
   localparam int SHIFT_W     = SUM_W - COEF_FRAC;
   localparam int NUM_CH      = 3;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic [REG_W-1:0]         chan_type;

   // rows: red, green, blue; columns: luma, blue chroma, red chroma
   localparam coef_type KMAT [NUM_CH][NUM_CH] = '{
      '{COEF_W'(16777216), COEF_W'(-617),      COEF_W'(23521489)},
      '{COEF_W'(16782249), COEF_W'(-5773459),  COEF_W'(-11980825)},
      '{COEF_W'(16774246), COEF_W'(29729898),  COEF_W'(-134)}
   };

   localparam sum_type ROUND_HALF = SUM_W'(64'sd1 << (COEF_FRAC - 1));

   localparam logic [CSR_IDX_W-1:0] CSR_CLAMP_LIMIT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHROMA_OFFSET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CB_SIGNED     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CR_SIGNED     = 2'd3;

   localparam logic [REG_W-1:0] CLAMP_LIMIT_RESET   = 16'd255;
   localparam logic [REG_W-1:0] CHROMA_OFFSET_RESET = 16'd128;

   typedef struct packed {
      logic [REG_W-1:0] clamp_limit;
      logic [REG_W-1:0] chroma_offset;
      logic             cb_signed;
      logic             cr_signed;
   } cfg_type;

   typedef struct packed {
      logic signed [IN_W-1:0]  luma;
      logic signed [CHR_W-1:0] cb;
      logic signed [CHR_W-1:0] cr;
   } pix_type;

endpackage

@@ hw/rtl/eycc_req_if.sv @@
// Input channel: one pixel word of luma and two chroma samples.
// Depends on eycc_pkg.
interface eycc_req_if;
   import eycc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic signed [IN_W-1:0] luma;
   logic signed [IN_W-1:0] chroma_blue;
   logic signed [IN_W-1:0] chroma_red;

   modport source (output valid, luma, chroma_blue, chroma_red, input ready);
   modport sink   (input valid, luma, chroma_blue, chroma_red, output ready);
endinterface

@@ hw/rtl/eycc_rsp_if.sv @@
// Result channel: one word of red, green and blue.
// Depends on eycc_pkg.
interface eycc_rsp_if;
   import eycc_pkg::*;

   logic             valid;
   logic             ready;
   logic [REG_W-1:0] red;
   logic [REG_W-1:0] green;
   logic [REG_W-1:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

@@ hw/rtl/eycc_offset.sv @@
// Stage one: sign-extend the chroma samples and remove the chroma offset from unsigned chroma.
// Depends on eycc_pkg.
module eycc_offset (
   input  logic                             clock,
   input  logic                             reset,
   input  eycc_pkg::cfg_type                cfg,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic signed [eycc_pkg::IN_W-1:0] luma,
   input  logic signed [eycc_pkg::IN_W-1:0] chroma_blue,
   input  logic signed [eycc_pkg::IN_W-1:0] chroma_red,
   output logic                             out_valid,
   input  logic                             out_ready,
   output eycc_pkg::pix_type                out_pix
);
   import eycc_pkg::*;

   logic                    valid_ff;
   pix_type                 pix_ff;
   pix_type                 pix_in;
   logic signed [CHR_W-1:0] flip_sx;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      flip_sx     = $signed({{(CHR_W - REG_W){1'b0}}, cfg.chroma_offset});
      pix_in.luma = luma;
      pix_in.cb   = CHR_W'(chroma_blue) - (cfg.cb_signed ? '0 : flip_sx);
      pix_in.cr   = CHR_W'(chroma_red)  - (cfg.cr_signed ? '0 : flip_sx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         pix_ff <= pix_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pix   = pix_ff;
endmodule

@@ hw/rtl/eycc_matrix.sv @@
// Stages two and three: the nine coefficient products, then the three
// channel sums with the rounding half added. Depends on eycc_pkg.
module eycc_matrix (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  eycc_pkg::pix_type in_pix,
   output logic              out_valid,
   input  logic              out_ready,
   output eycc_pkg::sum_type out_sum [eycc_pkg::NUM_CH]
);
   import eycc_pkg::*;

   logic                    prod_valid_ff;
   prod_type                prod_ff [NUM_CH][NUM_CH];
   prod_type                prod_in [NUM_CH][NUM_CH];
   logic                    sum_valid_ff;
   sum_type                 sum_ff  [NUM_CH];
   sum_type                 sum_in  [NUM_CH];
   logic signed [CHR_W-1:0] ops     [NUM_CH];
   logic                    sum_adv;
   logic                    prod_adv;

   assign sum_adv  = !sum_valid_ff || out_ready;
   assign prod_adv = !prod_valid_ff || sum_adv;
   assign in_ready = prod_adv;

   always_comb begin
      ops[0] = CHR_W'(in_pix.luma);
      ops[1] = in_pix.cb;
      ops[2] = in_pix.cr;
      for (int r = 0; r < NUM_CH; r++) begin
         for (int c = 0; c < NUM_CH; c++) begin
            prod_in[r][c] = PROD_W'(KMAT[r][c]) * PROD_W'(ops[c]);
         end
      end
   end

   always_comb begin
      for (int r = 0; r < NUM_CH; r++) begin
         sum_in[r] = SUM_W'(prod_ff[r][0]) + SUM_W'(prod_ff[r][1])
                   + SUM_W'(prod_ff[r][2]) + ROUND_HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         if (prod_adv) begin
            prod_valid_ff <= in_valid;
         end
         if (sum_adv) begin
            sum_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && prod_adv) begin
         prod_ff <= prod_in;
      end
      if (prod_valid_ff && sum_adv) begin
         sum_ff <= sum_in;
      end
   end

   assign out_valid = sum_valid_ff;
   assign out_sum   = sum_ff;
endmodule

@@ hw/rtl/eycc_clamp.sv @@
// Stage four: drop the fraction, clamp to [0, clamp limit] and hold the
// result word for the output channel. Depends on eycc_pkg.
module eycc_clamp (
   input  logic               clock,
   input  logic               reset,
   input  logic [eycc_pkg::REG_W-1:0] clamp_limit,
   input  logic               in_valid,
   output logic               in_ready,
   input  eycc_pkg::sum_type  in_sum [eycc_pkg::NUM_CH],
   output logic               out_valid,
   input  logic               out_ready,
   output eycc_pkg::chan_type out_chan [eycc_pkg::NUM_CH]
);
   import eycc_pkg::*;

   logic                      valid_ff;
   chan_type                  chan_ff [NUM_CH];
   chan_type                  chan_in [NUM_CH];
   logic signed [SHIFT_W-1:0] shv     [NUM_CH];

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         shv[c] = $signed(in_sum[c][SUM_W-1:COEF_FRAC]);
         if (shv[c][SHIFT_W-1]) begin
            chan_in[c] = '0;
         end else if ($unsigned(shv[c]) > SHIFT_W'(clamp_limit)) begin
            chan_in[c] = clamp_limit;
         end else begin
            chan_in[c] = REG_W'($unsigned(shv[c]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         chan_ff <= chan_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_chan  = chan_ff;
endmodule

@@ hw/rtl/eycc_to_rgb_rounding.sv @@
// Extended YCC to RGB converter, one pixel word per clock while the
// result side keeps up. Each word carries a luma and two chroma samples;
// unsigned chroma has the chroma offset removed, the 3x3 matrix is applied
// in fixed point with 24 fractional bits, one half is added, the fraction
// dropped and each channel clamped to [0, clamp limit]. The word passes four
// register stages: offset removal, coefficient products, channel sums, and
// clamp into the output register. The accepted input word is captured into
// the offset register and moves on through the product, sum and output registers.
// A new word is accepted every cycle while the result side keeps up; a
// stall on the result side holds each full stage in place and propagates
// back as ready low only once every stage is full, so bubbles are
// squeezed out first. Configuration writes take effect at the next edge
// and are meant for idle periods. Depends on eycc_pkg, eycc_req_if, eycc_rsp_if.
`include "eycc_to_rgb_rounding_assert.svh"

module eycc_to_rgb_rounding (
   input  logic                               clock,
   input  logic                               reset,
   eycc_req_if.sink                           req_if,
   eycc_rsp_if.source                         rsp_if,
   input  logic                               csr_write_enable,
   input  logic [eycc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [eycc_pkg::REG_W-1:0]         csr_write_data
);
   import eycc_pkg::*;

   cfg_type  cfg_ff;
   cfg_type  cfg_in;

   logic     ofs_valid;
   logic     mat_ready;
   pix_type  ofs_pix;
   logic     mat_valid;
   logic     clp_ready;
   sum_type  mat_sum [NUM_CH];
   chan_type clp_chan [NUM_CH];

   // Register file: decode the write, drop unused upper bits
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CLAMP_LIMIT:   cfg_in.clamp_limit   = csr_write_data;
            CSR_CHROMA_OFFSET: cfg_in.chroma_offset = csr_write_data;
            CSR_CB_SIGNED:     cfg_in.cb_signed     = csr_write_data[0];
            CSR_CR_SIGNED:     cfg_in.cr_signed     = csr_write_data[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clamp_limit   <= CLAMP_LIMIT_RESET;
         cfg_ff.chroma_offset <= CHROMA_OFFSET_RESET;
         cfg_ff.cb_signed     <= 1'b0;
         cfg_ff.cr_signed     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Stage one: remove chroma offset from unsigned chroma
   eycc_offset u_offset (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_if.valid),
      .in_ready    (req_if.ready),
      .luma        (req_if.luma),
      .chroma_blue (req_if.chroma_blue),
      .chroma_red  (req_if.chroma_red),
      .out_valid   (ofs_valid),
      .out_ready   (mat_ready),
      .out_pix     (ofs_pix)
   );

   // Stages two and three: products, then rounded sums
   eycc_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ofs_valid),
      .in_ready  (mat_ready),
      .in_pix    (ofs_pix),
      .out_valid (mat_valid),
      .out_ready (clp_ready),
      .out_sum   (mat_sum)
   );

   // Stage four: floor, clamp, hold the result word
   eycc_clamp u_clamp (
      .clock       (clock),
      .reset       (reset),
      .clamp_limit (cfg_ff.clamp_limit),
      .in_valid    (mat_valid),
      .in_ready    (clp_ready),
      .in_sum      (mat_sum),
      .out_valid   (rsp_if.valid),
      .out_ready   (rsp_if.ready),
      .out_chan    (clp_chan)
   );

   assign rsp_if.red   = clp_chan[0];
   assign rsp_if.green = clp_chan[1];
   assign rsp_if.blue  = clp_chan[2];

   // Input may only back up once every stage holds a word and the
   // result side is stalled
   `EYCC_ASSERT(a_ready_only_when_full, clock, reset,
      !req_if.ready |-> (ofs_valid && mat_valid && rsp_if.valid && !rsp_if.ready))

   // A sum word refused by the clamp stage must still be there next cycle
   `EYCC_ASSERT(a_sum_held_on_stall, clock, reset,
      (mat_valid && !clp_ready) |=> mat_valid)

endmodule
